### hw/rtl/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg
// Shared types, constants and calendar helpers for the Gregorian date stepper.
// ----------------------------------------------------------------------------
package gds_pkg;

    localparam int unsigned MAX_OFFSET_DEF = 65535;
    localparam int unsigned YEAR_MAX_DEF   = 9999;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 16;
    localparam int DOY_W   = 9;
    // The working day count holds a day of year plus or minus a full offset.
    localparam int T_W     = OFF_W + 2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2022;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd9;
    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd29;

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_INC  = 3'd1,
        OP_DEC  = 3'd2,
        OP_ADD  = 3'd3,
        OP_SUB  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic init;
        logic year_step;
        logic month_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic walk;
        logic year_done;
        logic month_done;
    } t_status;

    // Divisibility by 25 uses a reciprocal multiply, exact for any 14-bit year.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [28:0]       prod;
        logic [9:0]        q;
        logic [YEAR_W-1:0] q25;
        logic              div25;
        prod  = {15'd0, y} * 29'd20972;
        q     = prod[28:19];
        q25   = ({4'd0, q} << 4) + ({4'd0, q} << 3) + {4'd0, q};
        div25 = (q25 == y);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0]  y,
                                                    input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = is_leap(y) ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [DOY_W-1:0] year_days(input logic [YEAR_W-1:0] y);
        return is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    // Days before the first of month m in a common year.
    function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] c;
        case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/gds_ctrl.sv
// ----------------------------------------------------------------------------
// gds_ctrl
// Sequencer for the date stepper: input handshake, walk steps, result register.
// ----------------------------------------------------------------------------
module gds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    input  gds_pkg::t_status i_status,
    output gds_pkg::t_cmd    o_cmd
);
    import gds_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_finish;

    assign w_finish = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_state = i_status.walk ? S_YEAR : S_DONE;
            end
            S_YEAR: begin
                if (i_status.year_done) begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (i_status.month_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_s_axis_tready  = (r_state == S_IDLE);
        o_cmd.capture    = (r_state == S_IDLE) && i_s_axis_tvalid;
        o_cmd.init       = (r_state == S_INIT);
        o_cmd.year_step  = (r_state == S_YEAR);
        o_cmd.month_step = (r_state == S_MONTH);
        o_cmd.finish     = w_finish;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_finish) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

endmodule

### hw/rtl/gds_datapath.sv
// ----------------------------------------------------------------------------
// gds_datapath
// Date store, operand capture, year and month walk, and result register.
// ----------------------------------------------------------------------------
module gds_datapath #(
    parameter int unsigned MAX_OFFSET = gds_pkg::MAX_OFFSET_DEF,
    parameter int unsigned YEAR_MAX   = gds_pkg::YEAR_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gds_pkg::t_cmd                  i_cmd,
    input  logic [2:0]                     i_op,
    input  logic [gds_pkg::YEAR_W-1:0]     i_load_year,
    input  logic [gds_pkg::MONTH_W-1:0]    i_load_month,
    input  logic [gds_pkg::DAY_W-1:0]      i_load_day,
    input  logic [gds_pkg::OFF_W-1:0]      i_offset_days,
    output gds_pkg::t_status               o_status,
    output logic [gds_pkg::YEAR_W-1:0]     o_out_year,
    output logic [gds_pkg::MONTH_W-1:0]    o_out_month,
    output logic [gds_pkg::DAY_W-1:0]      o_out_day,
    output logic                           o_ok
);
    import gds_pkg::*;

    localparam logic [19:0]       MaxOff  = MAX_OFFSET[19:0];
    localparam logic [YEAR_W-1:0] YearTop = YEAR_MAX[YEAR_W-1:0];

    // Stored date.
    logic [YEAR_W-1:0]  r_cur_y;
    logic [MONTH_W-1:0] r_cur_m;
    logic [DAY_W-1:0]   r_cur_d;

    // Captured operands.
    logic [2:0]         r_op;
    logic [YEAR_W-1:0]  r_ly;
    logic [MONTH_W-1:0] r_lm;
    logic [DAY_W-1:0]   r_ld;
    logic [OFF_W-1:0]   r_off;
    logic               r_sub;

    // Walk state.
    logic [YEAR_W-1:0]    r_wy;
    logic [MONTH_W-1:0]   r_wm;
    logic signed [T_W-1:0] r_t;
    logic                 r_fail;

    logic [OFF_W-1:0]     w_off;
    logic [DOY_W-1:0]     w_doy;
    logic [DOY_W-1:0]     w_ylen_cur;
    logic [DOY_W-1:0]     w_ylen_prev;
    logic [DAY_W-1:0]     w_mlen;
    logic                 w_t_neg;
    logic                 w_t_over;
    logic                 w_load_ok;
    logic                 w_walk;
    logic                 w_walk_ok;

    always_comb begin
        if ({4'd0, i_offset_days} > MaxOff) begin
            w_off = MaxOff[OFF_W-1:0];
        end else begin
            w_off = i_offset_days;
        end
    end

    assign w_walk = (r_op == OP_INC) || (r_op == OP_DEC) ||
                    (r_op == OP_ADD) || (r_op == OP_SUB);

    assign w_doy = days_before_month(r_cur_m)
                 + (((r_cur_m > 4'd2) && is_leap(r_cur_y)) ? 9'd1 : 9'd0)
                 + {4'd0, r_cur_d} - 9'd1;

    assign w_ylen_cur  = year_days(r_wy);
    assign w_ylen_prev = year_days(r_wy - 14'd1);
    assign w_mlen      = month_days(r_wy, r_wm);
    assign w_t_neg     = r_t[T_W-1];
    assign w_t_over    = !w_t_neg && (r_t >= $signed({{(T_W-DOY_W){1'b0}}, w_ylen_cur}));

    assign w_load_ok = (r_ly >= 14'd1) && (r_ly <= YearTop) &&
                       (r_ld >= 5'd1) && (r_ld <= month_days(r_ly, r_lm));

    // The walked date must also end at or below the top year, since the
    // starting year may lie above it.
    assign w_walk_ok = !r_fail && (r_wy <= YearTop);

    assign o_status.walk       = w_walk;
    assign o_status.year_done  = r_fail || (!w_t_neg && !w_t_over);
    assign o_status.month_done = r_fail || (r_wm == 4'd12) ||
                                 (r_t < $signed({{(T_W-DAY_W){1'b0}}, w_mlen}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_op;
            r_ly <= i_load_year;
            r_lm <= i_load_month;
            r_ld <= i_load_day;
            case (i_op)
                OP_INC, OP_DEC: r_off <= 16'd1;
                default:        r_off <= w_off;
            endcase
            r_sub <= (i_op == OP_DEC) || (i_op == OP_SUB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_wy   <= r_cur_y;
            r_wm   <= 4'd1;
            r_fail <= 1'b0;
            if (r_sub) begin
                r_t <= $signed({{(T_W-DOY_W){1'b0}}, w_doy}) - $signed({2'b00, r_off});
            end else begin
                r_t <= $signed({{(T_W-DOY_W){1'b0}}, w_doy}) + $signed({2'b00, r_off});
            end
        end else if (i_cmd.year_step && !r_fail) begin
            if (w_t_neg) begin
                if (r_wy == 14'd1) begin
                    r_fail <= 1'b1;
                end else begin
                    r_wy <= r_wy - 14'd1;
                    r_t  <= r_t + $signed({{(T_W-DOY_W){1'b0}}, w_ylen_prev});
                end
            end else if (w_t_over) begin
                if (r_wy >= YearTop) begin
                    r_fail <= 1'b1;
                end else begin
                    r_wy <= r_wy + 14'd1;
                    r_t  <= r_t - $signed({{(T_W-DOY_W){1'b0}}, w_ylen_cur});
                end
            end
        end else if (i_cmd.month_step && !o_status.month_done) begin
            r_t  <= r_t - $signed({{(T_W-DAY_W){1'b0}}, w_mlen});
            r_wm <= r_wm + 4'd1;
        end
    end

    // Result register and store update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_y <= RESET_YEAR;
            r_cur_m <= RESET_MONTH;
            r_cur_d <= RESET_DAY;
        end else if (i_cmd.finish) begin
            if ((r_op == OP_LOAD) && w_load_ok) begin
                r_cur_y <= r_ly;
                r_cur_m <= r_lm;
                r_cur_d <= r_ld;
            end else if (((r_op == OP_INC) || (r_op == OP_DEC)) && w_walk_ok) begin
                r_cur_y <= r_wy;
                r_cur_m <= r_wm;
                r_cur_d <= r_t[DAY_W-1:0] + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if ((r_op == OP_LOAD) && w_load_ok) begin
                o_out_year  <= r_ly;
                o_out_month <= r_lm;
                o_out_day   <= r_ld;
                o_ok        <= 1'b1;
            end else if (w_walk && w_walk_ok) begin
                o_out_year  <= r_wy;
                o_out_month <= r_wm;
                o_out_day   <= r_t[DAY_W-1:0] + 5'd1;
                o_ok        <= 1'b1;
            end else begin
                o_out_year  <= r_cur_y;
                o_out_month <= r_cur_m;
                o_out_day   <= r_cur_d;
                o_ok        <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/gregorian_date_stepper_core.sv
// ----------------------------------------------------------------------------
// gregorian_date_stepper_core
// Gregorian calendar date store with load, step and add/subtract-days items.
// ----------------------------------------------------------------------------
// The block holds one Gregorian date (reset value 2022-09-29) and takes one
// item at a time. Each item yields exactly one result item with an ok flag.
// A load or an unused op code goes from acceptance through the init and
// done states, and its result is registered as it leaves done. Increment,
// decrement, add and subtract convert the stored date to a day of year,
// apply the offset, then walk one year per cycle and one month per cycle
// until the count lands inside a month. The result sits in an output
// register, so the block accepts the next item while a result still waits
// for the sink; a second finished result then holds the block in its done
// state for as long as the sink stalls.
// ----------------------------------------------------------------------------
module gregorian_date_stepper_core #(
    parameter int unsigned MAX_OFFSET = gds_pkg::MAX_OFFSET_DEF,
    parameter int unsigned YEAR_MAX   = gds_pkg::YEAR_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // Fields from bit 0: load_year[13:0], load_month[17:14], load_day[22:18],
    // offset_days[38:23], zero pad [39].
    input  logic [gds_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // Fields from bit 0: op[2:0].
    input  logic [2:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // Fields from bit 0: out_year[13:0], out_month[17:14], out_day[22:18],
    // zero pad [23].
    output logic [gds_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // Fields from bit 0: ok[0].
    output logic                                o_m_axis_tuser
);
    import gds_pkg::*;

    t_cmd               w_cmd;
    t_status            w_status;
    logic [YEAR_W-1:0]  w_out_year;
    logic [MONTH_W-1:0] w_out_month;
    logic [DAY_W-1:0]   w_out_day;

    // The sequencer owns both handshakes; the datapath owns every date value.
    gds_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    gds_datapath #(
        .MAX_OFFSET (MAX_OFFSET),
        .YEAR_MAX   (YEAR_MAX)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_op          (i_s_axis_tuser),
        .i_load_year   (i_s_axis_tdata[13:0]),
        .i_load_month  (i_s_axis_tdata[17:14]),
        .i_load_day    (i_s_axis_tdata[22:18]),
        .i_offset_days (i_s_axis_tdata[38:23]),
        .o_status      (w_status),
        .o_out_year    (w_out_year),
        .o_out_month   (w_out_month),
        .o_out_day     (w_out_day),
        .o_ok          (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {1'b0, w_out_day, w_out_month, w_out_year};

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Gregorian date stepper core.
// ----------------------------------------------------------------------------
// Items go in on the slave stream: the op code in tuser, and the load date and
// day offset in tdata. A calendar model in this file tracks the stored date.
// It predicts one result for every item that the block accepts. A monitor
// compares each returned date and ok flag with the oldest prediction.
// Directed items cover leap-year rules, load checks, both ends of the year
// range and the unused op codes. Random traffic follows in three idle
// patterns. A long sink hold-off fills the block and makes it stall its input.
// ----------------------------------------------------------------------------
module tb_top;

    import gds_pkg::*;

    localparam int unsigned OFFSET_LIMIT = MAX_OFFSET_DEF;
    localparam int unsigned YEAR_LIMIT   = YEAR_MAX_DEF;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 250;

    // Op codes the block decodes as no operation.
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               ok;
    } t_date_result;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic [2:0]             i_s_axis_tuser  = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;

    // The calendar model's copy of the stored date.
    int cal_year;
    int cal_month;
    int cal_day;

    t_date_result expected_dates[$];
    int           mismatch_count = 0;
    int           stall_cycles   = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    bit           hold_request   = 1'b0;
    int           hold_left      = 0;

    gregorian_date_stepper_core #(
        .MAX_OFFSET (OFFSET_LIMIT),
        .YEAR_MAX   (YEAR_LIMIT)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------------

    // A year is a leap year on every fourth year, except on centuries that are
    // not a multiple of 400.
    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_len(input int y, input int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Days from 0001-01-01 up to January 1st of year y.
    function automatic int days_to_year(input int y);
        int p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic int date_to_serial(input int y, input int m, input int d);
        int s;
        s = days_to_year(y);
        for (int k = 1; k < m; k++) begin
            s += month_len(y, k);
        end
        return s + d - 1;
    endfunction

    function automatic void serial_to_date(input int s, output int y, output int m,
                                           output int d);
        longint guess;
        guess = 1 + (longint'(s) * 400) / 146097;
        y = (guess < 1) ? 1 : int'(guess);
        while (y > 1 && days_to_year(y) > s) begin
            y--;
        end
        while (days_to_year(y + 1) <= s) begin
            y++;
        end
        s -= days_to_year(y);
        m = 1;
        while (m < 12 && s >= month_len(y, m)) begin
            s -= month_len(y, m);
            m++;
        end
        d = s + 1;
    endfunction

    function automatic void reset_calendar();
        cal_year  = int'(RESET_YEAR);
        cal_month = int'(RESET_MONTH);
        cal_day   = int'(RESET_DAY);
    endfunction

    // Works out the result of one item and updates the stored date on a good
    // load, increment or decrement. Failures return the stored date, ok low.
    function automatic t_date_result predict_date(input logic [2:0] op,
                                                  input logic [IN_TDATA_W-1:0] fields);
        t_date_result res;
        int           ly;
        int           lm;
        int           ld;
        int           step;
        int           delta;
        int           serial;
        int           ny;
        int           nm;
        int           nd;
        ly    = int'(fields[13:0]);
        lm    = int'(fields[17:14]);
        ld    = int'(fields[22:18]);
        step  = int'(fields[38:23]);
        delta = 0;
        if (step > OFFSET_LIMIT) begin
            step = OFFSET_LIMIT;
        end
        res.year  = cal_year[YEAR_W-1:0];
        res.month = cal_month[MONTH_W-1:0];
        res.day   = cal_day[DAY_W-1:0];
        res.ok    = 1'b0;
        case (op)
            OP_LOAD: begin
                if (ly >= 1 && ly <= YEAR_LIMIT && lm >= 1 && lm <= 12 &&
                    ld >= 1 && ld <= month_len(ly, lm)) begin
                    cal_year  = ly;
                    cal_month = lm;
                    cal_day   = ld;
                    res.year  = fields[13:0];
                    res.month = fields[17:14];
                    res.day   = fields[22:18];
                    res.ok    = 1'b1;
                end
            end
            OP_INC, OP_DEC, OP_ADD, OP_SUB: begin
                case (op)
                    OP_INC:  delta = 1;
                    OP_DEC:  delta = -1;
                    OP_ADD:  delta = step;
                    default: delta = -step;
                endcase
                serial = date_to_serial(cal_year, cal_month, cal_day) + delta;
                // The result must stay within 0001-01-01 and the last day of
                // the top year.
                if (serial >= 0 && serial < days_to_year(YEAR_LIMIT + 1)) begin
                    serial_to_date(serial, ny, nm, nd);
                    res.year  = ny[YEAR_W-1:0];
                    res.month = nm[MONTH_W-1:0];
                    res.day   = nd[DAY_W-1:0];
                    res.ok    = 1'b1;
                    if (op == OP_INC || op == OP_DEC) begin
                        cal_year  = ny;
                        cal_month = nm;
                        cal_day   = nd;
                    end
                end
            end
            default: begin
                // Unused op codes leave everything alone.
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor and watchdog
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Checks the output first and then predicts the input item of the same
    // edge, so the two never depend on process order within one time step.
    always @(posedge i_clk) begin
        t_date_result want;
        if (!i_rst_n) begin
            reset_calendar();
            expected_dates.delete();
            stall_cycles = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("unexpected result year", int'(o_m_axis_tdata[13:0]), -1);
                end else begin
                    want = expected_dates.pop_front();
                    if (o_m_axis_tdata[13:0] !== want.year)
                        report_mismatch("year", int'(o_m_axis_tdata[13:0]), int'(want.year));
                    if (o_m_axis_tdata[17:14] !== want.month)
                        report_mismatch("month", int'(o_m_axis_tdata[17:14]),
                                        int'(want.month));
                    if (o_m_axis_tdata[22:18] !== want.day)
                        report_mismatch("day", int'(o_m_axis_tdata[22:18]), int'(want.day));
                    if (o_m_axis_tuser !== want.ok)
                        report_mismatch("ok", int'(o_m_axis_tuser), int'(want.ok));
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_dates.push_back(predict_date(i_s_axis_tuser, i_s_axis_tdata));
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("[%0t] timeout: no item moved for %0d cycles",
                             $realtime, STALL_LIMIT);
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink
    // ------------------------------------------------------------------------

    // Random ready, or held low on request until the hold count runs out.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Item source
    // ------------------------------------------------------------------------

    task automatic send_item(input logic [2:0] op, input logic [YEAR_W-1:0] yr,
                             input logic [MONTH_W-1:0] mo, input logic [DAY_W-1:0] dy,
                             input logic [OFF_W-1:0] off);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {1'b0, off, dy, mo, yr};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
    endtask

    // Drops valid and waits until every predicted result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_dates.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_reset_value();
        // Zero offset returns the reset date untouched.
        send_item(OP_ADD, '0, '0, '0, 16'd0);
    endtask

    task automatic test_load_checks();
        send_item(OP_LOAD, 14'd2000, 4'd2, 5'd29, 16'd0);      // 400-year leap
        send_item(OP_LOAD, 14'd1900, 4'd2, 5'd29, 16'd0);      // century, no leap
        send_item(OP_LOAD, 14'd2024, 4'd2, 5'd29, 16'd0);      // ordinary leap
        send_item(OP_LOAD, 14'd2023, 4'd2, 5'd29, 16'd0);      // common year
        send_item(OP_LOAD, 14'd0, 4'd6, 5'd15, 16'd0);         // year zero
        send_item(OP_LOAD, 14'h3FFF, 4'd12, 5'd31, 16'hFFFF);  // year past the top
        send_item(OP_LOAD, 14'd2023, 4'd0, 5'd10, 16'd0);      // month zero
        send_item(OP_LOAD, 14'd2023, 4'hF, 5'd10, 16'd0);      // month fifteen
        send_item(OP_LOAD, 14'd2023, 4'd4, 5'd31, 16'd0);      // past month end
        send_item(OP_LOAD, 14'd2023, 4'd4, 5'd0, 16'd0);       // day zero
        send_item(OP_LOAD, 14'd2023, 4'd1, 5'd31, 16'd0);
    endtask

    task automatic test_range_limits();
        send_item(OP_LOAD, 14'd1, 4'd1, 5'd1, 16'd0);
        send_item(OP_DEC, '0, '0, '0, 16'd0);          // falls before year one
        send_item(OP_SUB, '0, '0, '0, 16'd1);
        send_item(OP_ADD, '0, '0, '0, 16'hFFFF);
        send_item(OP_LOAD, YEAR_LIMIT[YEAR_W-1:0], 4'd12, 5'd31, 16'd0);
        send_item(OP_INC, '0, '0, '0, 16'd0);          // runs past the top year
        send_item(OP_ADD, '0, '0, '0, 16'd1);
        send_item(OP_SUB, '0, '0, '0, 16'hFFFF);
    endtask

    task automatic test_day_steps();
        send_item(OP_LOAD, 14'd1900, 4'd2, 5'd28, 16'd0);
        send_item(OP_INC, '0, '0, '0, 16'd0);
        send_item(OP_DEC, '0, '0, '0, 16'd0);
        send_item(OP_LOAD, 14'd2023, 4'd12, 5'd31, 16'd0);
        send_item(OP_INC, '0, '0, '0, 16'd0);
    endtask

    task automatic test_unused_ops();
        for (int code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++) begin
            send_item(code[2:0], 14'($urandom), 4'($urandom), 5'($urandom), 16'($urandom));
        end
    endtask

    // Small offsets keep most add and subtract items short.
    function automatic logic [OFF_W-1:0] random_offset();
        if ($urandom_range(99) < 70)
            return OFF_W'($urandom_range(400));
        return OFF_W'($urandom);
    endfunction

    // Mostly valid loads and steps around a live date, with some noise.
    task automatic send_random_item();
        int r;
        int y;
        int m;
        r = $urandom_range(99);
        if (r < 20) begin
            if ($urandom_range(9) == 0)
                y = ($urandom_range(1)) ? $urandom_range(3, 1)
                                        : $urandom_range(YEAR_LIMIT, YEAR_LIMIT - 2);
            else
                y = $urandom_range(YEAR_LIMIT, 1);
            m = $urandom_range(12, 1);
            send_item(OP_LOAD, y[YEAR_W-1:0], m[MONTH_W-1:0],
                      DAY_W'($urandom_range(month_len(y, m), 1)), 16'($urandom));
        end else if (r < 28) begin
            send_item(OP_LOAD, 14'($urandom), 4'($urandom), 5'($urandom), 16'($urandom));
        end else if (r < 45) begin
            send_item(OP_INC, 14'($urandom), 4'($urandom), 5'($urandom), 16'($urandom));
        end else if (r < 60) begin
            send_item(OP_DEC, 14'($urandom), 4'($urandom), 5'($urandom), 16'($urandom));
        end else if (r < 75) begin
            send_item(OP_ADD, 14'($urandom), 4'($urandom), 5'($urandom), random_offset());
        end else if (r < 90) begin
            send_item(OP_SUB, 14'($urandom), 4'($urandom), 5'($urandom), random_offset());
        end else if (r < 95) begin
            send_item(3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)), 14'($urandom),
                      4'($urandom), 5'($urandom), 16'($urandom));
        end else begin
            send_item(3'($urandom), 14'($urandom), 4'($urandom), 5'($urandom),
                      random_offset());
        end
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_item();
        drain_results();
    endtask

    // The sink stops for a long stretch while the source keeps offering
    // items, so the block fills its output register and lowers tready.
    task automatic test_backpressure();
        int saved_send;
        int saved_recv;
        saved_send    = send_idle_pct;
        saved_recv    = recv_idle_pct;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge i_clk);
        hold_request = 1'b1;
        repeat (12) send_random_item();
        drain_results();
        send_idle_pct = saved_send;
        recv_idle_pct = saved_recv;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 83;
        test_reset_value();
        test_load_checks();
        test_range_limits();
        test_day_steps();
        test_unused_ops();
        drain_results();
        test_random_traffic(420);

        send_idle_pct = 83;
        recv_idle_pct = 32;
        test_random_traffic(420);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(420);

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_dates.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
